[hdl/dhmmq_pkg.sv]
// package for the dual heap min/max queue
// holds command, status and heap operation codes used by the back end and the heaps; no dependencies
package dhmmq_pkg;
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // operations the back end issues to each heap
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_SEARCH = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
endpackage

[hdl/dhmmq_if.sv]
// valid/ready channel interfaces for the queue
// depends on nothing; payload fields carried per channel
interface dhmmq_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic signed [31:0] value;
    modport source (output valid, command, value, input ready);
    modport sink (input valid, command, value, output ready);
endinterface

interface dhmmq_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic signed [31:0] current_max;
    logic signed [31:0] current_min;
    logic [10:0] entry_count;
    modport source (output valid, status, current_max, current_min, entry_count, input ready);
    modport sink (input valid, status, current_max, current_min, entry_count, output ready);
endinterface

[hdl/dhmmq_front.sv]
// front end: accepts command transactions into a two-entry queue
// depends on dhmmq_if; wraps values to VALUE_BITS
module dhmmq_front #(
    parameter int VALUE_BITS = 32
) (
    input  logic clk,
    input  logic rst_n,
    dhmmq_cmd_if.sink cmd,
    output logic                   q_valid,
    input  logic                   q_pop,
    output logic [1:0]             q_command,
    output logic [VALUE_BITS-1:0]  q_value
);
    logic [1:0]            cmd_reg [2];
    logic [VALUE_BITS-1:0] val_reg [2];
    logic                  wp_reg, rp_reg, wp_next, rp_next;
    logic [1:0]            cnt_reg, cnt_next;
    logic                  push;
    logic [VALUE_BITS-1:0] wrapped;

    // sign extend or truncate to the storage width
    generate
        if (VALUE_BITS > 32)
        begin : g_wide
            assign wrapped = {{(VALUE_BITS-32){cmd.value[31]}}, cmd.value};
        end
        else
        begin : g_narrow
            assign wrapped = cmd.value[VALUE_BITS-1:0];
        end
    endgenerate

    assign cmd.ready = (cnt_reg != 2'd2);
    assign push      = cmd.valid && cmd.ready;
    assign q_valid   = (cnt_reg != 2'd0);
    assign q_command = cmd_reg[rp_reg];
    assign q_value   = val_reg[rp_reg];

    // pointer and fill bookkeeping
    always_comb
    begin
        wp_next  = wp_reg ^ push;
        rp_next  = rp_reg ^ q_pop;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // payload slots
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            cmd_reg[wp_reg] <= cmd.command;
            val_reg[wp_reg] <= wrapped;
        end
    end
endmodule

[hdl/dhmmq_heap.sv]
// one binary heap in a memory with a sequencer for insert, search and remove
// depends on dhmmq_pkg; IS_MAX selects heap order
module dhmmq_heap #(
    parameter int CAPACITY   = 1024,
    parameter int VALUE_BITS = 32,
    parameter bit IS_MAX     = 1'b1,
    parameter int CW         = $clog2(CAPACITY + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [1:0]            op,        // insert, search, remove
    input  logic [VALUE_BITS-1:0] value,
    input  logic [CW-1:0]         count,     // count before the operation
    output logic                  done,
    output logic                  found,
    output logic [VALUE_BITS-1:0] top
);
    localparam int AW = $clog2(CAPACITY + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_UPRD  = 4'd1;
    localparam logic [3:0] S_UPCMP = 4'd2;
    localparam logic [3:0] S_SRD   = 4'd3;
    localparam logic [3:0] S_SCMP  = 4'd4;
    localparam logic [3:0] S_RLAST = 4'd5;
    localparam logic [3:0] S_RWR   = 4'd6;
    localparam logic [3:0] S_DRDL  = 4'd7;
    localparam logic [3:0] S_DRDR  = 4'd8;
    localparam logic [3:0] S_DCMP  = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    logic [VALUE_BITS-1:0] mem [CAPACITY+1];
    logic [VALUE_BITS-1:0] rd_data, top_reg;
    logic [3:0]            st_reg;
    logic [AW-1:0]         pos_reg, lim_reg, hit_reg, rd_addr, best_reg;
    logic [VALUE_BITS-1:0] cur_reg, bestv_reg;
    logic                  found_reg, rd_en;
    logic [AW:0]           child;
    logic                  rgt_win;
    logic                  we_a, we_b;
    logic [AW-1:0]         wa_addr, wb_addr;
    logic [VALUE_BITS-1:0] wa_data, wb_data;

    // a above b in heap order
    function automatic logic above(input logic [VALUE_BITS-1:0] a,
                                   input logic [VALUE_BITS-1:0] b);
        if (IS_MAX)
            above = $signed(a) > $signed(b);
        else
            above = $signed(a) < $signed(b);
    endfunction

    assign done    = (st_reg == S_DONE);
    assign found   = found_reg;
    assign top     = top_reg;
    assign child   = {pos_reg, 1'b0};
    // right child exists and beats both the current value and the left child
    assign rgt_win = (child + (AW+1)'(1) <= {1'b0, lim_reg}) && above(rd_data, bestv_reg);

    // read port address per state
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = pos_reg;
        case (st_reg)
            S_UPRD:
            begin
                rd_en   = 1'b1;
                rd_addr = pos_reg >> 1;
            end
            S_SRD:
            begin
                rd_en   = 1'b1;
                rd_addr = pos_reg;
            end
            S_RLAST:
            begin
                rd_en   = 1'b1;
                rd_addr = lim_reg;
            end
            S_DRDL:
            begin
                rd_en   = 1'b1;
                rd_addr = child[AW-1:0];
            end
            S_DRDR:
            begin
                rd_en   = 1'b1;
                rd_addr = child[AW-1:0] + AW'(1);
            end
            default: rd_en = 1'b0;
        endcase
    end

    // two write ports: a swap moves one value each way in the same cycle
    always_comb
    begin
        we_a    = 1'b0;
        wa_addr = pos_reg;
        wa_data = rd_data;
        we_b    = 1'b0;
        wb_addr = pos_reg >> 1;
        wb_data = cur_reg;
        case (st_reg)
            S_IDLE:
            begin
                if (start && op == dhmmq_pkg::OP_INSERT)
                begin
                    we_a    = 1'b1;
                    wa_addr = AW'(count) + AW'(1);
                    wa_data = value;
                end
            end
            S_UPCMP:
            begin
                if (above(cur_reg, rd_data))
                begin
                    we_a = 1'b1;
                    we_b = 1'b1;
                end
            end
            S_RWR: we_a = 1'b1;
            S_DCMP:
            begin
                if (rgt_win)
                begin
                    we_a    = 1'b1;
                    we_b    = 1'b1;
                    wb_addr = child[AW-1:0] + AW'(1);
                end
                else if (best_reg != pos_reg)
                begin
                    we_a    = 1'b1;
                    wa_data = bestv_reg;
                    we_b    = 1'b1;
                    wb_addr = best_reg;
                end
            end
            default: we_a = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we_a)
            mem[wa_addr] <= wa_data;
        if (we_b)
            mem[wb_addr] <= wb_data;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= S_IDLE;
            found_reg <= 1'b0;
        end
        else
        begin
            case (st_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        case (op)
                            dhmmq_pkg::OP_INSERT:
                            begin
                                pos_reg <= AW'(count) + AW'(1);
                                cur_reg <= value;
                                st_reg  <= S_UPRD;
                            end
                            dhmmq_pkg::OP_SEARCH:
                            begin
                                pos_reg   <= AW'(1);
                                lim_reg   <= AW'(count);
                                cur_reg   <= value;
                                found_reg <= 1'b0;
                                st_reg    <= (count == '0) ? S_DONE : S_SRD;
                            end
                            default:
                            begin
                                pos_reg <= hit_reg;
                                lim_reg <= AW'(count);
                                st_reg  <= S_RLAST;
                            end
                        endcase
                    end
                end
                // sift up: compare with parent
                S_UPRD:
                begin
                    if (pos_reg <= AW'(1))
                        st_reg <= S_DONE;
                    else
                        st_reg <= S_UPCMP;
                end
                S_UPCMP:
                begin
                    if (above(cur_reg, rd_data))
                    begin
                        pos_reg <= pos_reg >> 1;
                        st_reg  <= S_UPRD;
                    end
                    else
                        st_reg <= S_DONE;
                end
                // linear search
                S_SRD: st_reg <= S_SCMP;
                S_SCMP:
                begin
                    if (rd_data == cur_reg)
                    begin
                        found_reg <= 1'b1;
                        hit_reg   <= pos_reg;
                        st_reg    <= S_DONE;
                    end
                    else if (pos_reg == lim_reg)
                        st_reg <= S_DONE;
                    else
                    begin
                        pos_reg <= pos_reg + AW'(1);
                        st_reg  <= S_SRD;
                    end
                end
                // move last entry into the hole
                S_RLAST: st_reg <= S_RWR;
                S_RWR:
                begin
                    cur_reg <= rd_data;
                    lim_reg <= lim_reg - AW'(1);
                    if (pos_reg == lim_reg)
                        st_reg <= S_DONE;
                    else
                        st_reg <= S_DRDL;
                end
                // sift down
                S_DRDL:
                begin
                    best_reg  <= pos_reg;
                    bestv_reg <= cur_reg;
                    if (child > {1'b0, lim_reg})
                        st_reg <= S_UPRD;
                    else
                        st_reg <= S_DRDR;
                end
                S_DRDR:
                begin
                    if (above(rd_data, bestv_reg))
                    begin
                        best_reg  <= child[AW-1:0];
                        bestv_reg <= rd_data;
                    end
                    st_reg <= S_DCMP;
                end
                S_DCMP:
                begin
                    if (rgt_win)
                    begin
                        pos_reg <= child[AW-1:0] + AW'(1);
                        st_reg  <= S_DRDL;
                    end
                    else if (best_reg != pos_reg)
                    begin
                        pos_reg <= best_reg;
                        st_reg  <= S_DRDL;
                    end
                    else
                        st_reg <= S_UPRD;
                end
                S_DONE: st_reg <= S_IDLE;
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    // top entry is read back after every operation
    always_ff @(posedge clk)
    begin
        if (st_reg == S_DONE)
            top_reg <= mem[1];
    end
endmodule

[hdl/dhmmq_back.sv]
// back end: runs one command on both heaps and builds the response
// depends on dhmmq_pkg, dhmmq_if and dhmmq_heap
module dhmmq_back #(
    parameter int CAPACITY   = 1024,
    parameter int VALUE_BITS = 32
) (
    input  logic clk,
    input  logic rst_n,
    input  logic                  q_valid,
    output logic                  q_pop,
    input  logic [1:0]            q_command,
    input  logic [VALUE_BITS-1:0] q_value,
    dhmmq_rsp_if.source rsp
);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_RUN  = 3'd1;
    localparam logic [2:0] B_SRCH = 3'd2;
    localparam logic [2:0] B_REM  = 3'd3;
    localparam logic [2:0] B_TOP  = 3'd4;
    localparam logic [2:0] B_OUT  = 3'd5;
    localparam logic [2:0] B_RMGO = 3'd6;

    logic [2:0]    st_reg;
    logic [CW-1:0] cnt_reg;
    logic [1:0]    cmd_reg, status_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic          hstart;
    logic [1:0]    hop;
    logic          is_full;
    logic          dmax, dmin, fmax, fmin, wmax, wmin;
    logic [VALUE_BITS-1:0] tmax, tmin;

    assign q_pop   = q_valid && (st_reg == B_IDLE);
    assign is_full = (cmd_reg == dhmmq_pkg::CMD_INSERT) && (cnt_reg == CW'(CAPACITY));

    dhmmq_heap #(.CAPACITY(CAPACITY), .VALUE_BITS(VALUE_BITS), .IS_MAX(1'b1)) u_max (
        .clk, .rst_n, .start(hstart), .op(hop), .value(val_reg), .count(cnt_reg),
        .done(dmax), .found(fmax), .top(tmax));
    dhmmq_heap #(.CAPACITY(CAPACITY), .VALUE_BITS(VALUE_BITS), .IS_MAX(1'b0)) u_min (
        .clk, .rst_n, .start(hstart), .op(hop), .value(val_reg), .count(cnt_reg),
        .done(dmin), .found(fmin), .top(tmin));

    // heap command issue
    always_comb
    begin
        hstart = 1'b0;
        hop    = dhmmq_pkg::OP_SEARCH;
        if (st_reg == B_RUN)
        begin
            hstart = (cmd_reg != dhmmq_pkg::CMD_QUERY) && !is_full;
            hop    = (cmd_reg == dhmmq_pkg::CMD_INSERT) ? dhmmq_pkg::OP_INSERT
                                                        : dhmmq_pkg::OP_SEARCH;
        end
        else if (st_reg == B_RMGO)
        begin
            hstart = 1'b1;
            hop    = dhmmq_pkg::OP_REMOVE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= B_IDLE;
            cnt_reg <= '0;
            wmax    <= 1'b0;
            wmin    <= 1'b0;
        end
        else
        begin
            case (st_reg)
                B_IDLE:
                begin
                    if (q_valid)
                    begin
                        cmd_reg <= (q_command == dhmmq_pkg::CMD_UNUSED) ? dhmmq_pkg::CMD_QUERY
                                                                        : q_command;
                        val_reg <= q_value;
                        st_reg  <= B_RUN;
                    end
                end
                B_RUN:
                begin
                    wmax <= 1'b0;
                    wmin <= 1'b0;
                    status_reg <= dhmmq_pkg::ST_OK;
                    if (is_full)
                    begin
                        status_reg <= dhmmq_pkg::ST_FULL;
                        st_reg     <= B_TOP;
                    end
                    else if (cmd_reg == dhmmq_pkg::CMD_QUERY)
                        st_reg <= B_TOP;
                    else
                        st_reg <= B_SRCH;
                end
                // wait for both heaps
                B_SRCH:
                begin
                    if (dmax) wmax <= 1'b1;
                    if (dmin) wmin <= 1'b1;
                    if ((wmax || dmax) && (wmin || dmin))
                    begin
                        wmax <= 1'b0;
                        wmin <= 1'b0;
                        if (cmd_reg == dhmmq_pkg::CMD_INSERT)
                        begin
                            cnt_reg <= cnt_reg + CW'(1);
                            st_reg  <= B_TOP;
                        end
                        else if (fmax && fmin)
                            st_reg <= B_RMGO;
                        else
                        begin
                            status_reg <= dhmmq_pkg::ST_NOT_FOUND;
                            st_reg     <= B_TOP;
                        end
                    end
                end
                // start the removal once both heaps are idle
                B_RMGO: st_reg <= B_REM;
                B_REM:
                begin
                    if (dmax) wmax <= 1'b1;
                    if (dmin) wmin <= 1'b1;
                    if ((wmax || dmax) && (wmin || dmin))
                    begin
                        wmax    <= 1'b0;
                        wmin    <= 1'b0;
                        cnt_reg <= cnt_reg - CW'(1);
                        st_reg  <= B_TOP;
                    end
                end
                B_TOP:
                begin
                    if (!(dmax || dmin))
                        st_reg <= B_OUT;
                    if (status_reg == dhmmq_pkg::ST_OK && cnt_reg == '0)
                        status_reg <= dhmmq_pkg::ST_EMPTY;
                end
                B_OUT:
                begin
                    if (rsp.ready)
                        st_reg <= B_IDLE;
                end
                default: st_reg <= B_IDLE;
            endcase
        end
    end

    assign rsp.valid       = (st_reg == B_OUT);
    assign rsp.status      = status_reg;
    assign rsp.current_max = (cnt_reg == '0) ? '0 : 32'($signed(tmax));
    assign rsp.current_min = (cnt_reg == '0) ? '0 : 32'($signed(tmin));
    assign rsp.entry_count = 11'(cnt_reg);
endmodule

[hdl/dual_heap_min_max_queue_core.sv]
// dual heap min/max priority queue
// cmd channel: one transaction per command (insert, delete, query);
// rsp channel: one transaction per command with status, max, min and count.
// one command runs at a time; a two-entry front queue takes commands while
// the back end works, and the next queued command starts the cycle after
// a response transaction is taken.
// insert: the new entry is written at the end of each heap and sifts up
// one heap level at a time.
// delete: a linear search over the entries, then the last entry moves
// into the hole and sifts down one level at a time, then up where needed.
// a missed delete ends after the search.
// both heaps run side by side, each on its own memory with two write ports.
// reset clears the count; heap memories need no clearing.
// a stalled response holds the back end; the front queue then fills and
// drops ready.
// depends on dhmmq_pkg, dhmmq_if, dhmmq_front, dhmmq_back
module dual_heap_min_max_queue_core #(
    parameter int CAPACITY   = 1024,
    parameter int VALUE_BITS = 32
) (
    input logic clk,
    input logic rst_n,
    dhmmq_cmd_if.sink   cmd,
    dhmmq_rsp_if.source rsp
);
    logic                  q_valid, q_pop;
    logic [1:0]            q_command;
    logic [VALUE_BITS-1:0] q_value;

    dhmmq_front #(.VALUE_BITS(VALUE_BITS)) u_front (
        .clk, .rst_n, .cmd, .q_valid, .q_pop, .q_command, .q_value);

    dhmmq_back #(.CAPACITY(CAPACITY), .VALUE_BITS(VALUE_BITS)) u_back (
        .clk, .rst_n, .q_valid, .q_pop, .q_command, .q_value, .rsp);
endmodule
